// ===== hdl/kvbel_pkg.sv =====
// ----------------------------------------------------------------------------
// kvbel_pkg
// Types and constants shared by the key/value blob entry locator.
// ----------------------------------------------------------------------------
package kvbel_pkg;

   localparam int POS_W  = 25;
   localparam int SKIP_W = 17;
   localparam int KLEN_W = 8;
   localparam int VLEN_W = 16;

   localparam logic [POS_W-1:0] POS_MAX  = {POS_W{1'b1}};
   localparam logic [7:0]       VERSION1 = 8'd1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_BAD   = 2'd1,
      ST_RANGE = 2'd2,
      ST_TRUNC = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] blob_byte;
      logic [7:0] entry_index;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [POS_W-1:0]  key_offset;
      logic [KLEN_W-1:0] key_length;
      logic [POS_W-1:0]  value_offset;
      logic [VLEN_W-1:0] value_length;
   } rsp_type;

endpackage

// ===== hdl/kvbel_ifs.sv =====
// ----------------------------------------------------------------------------
// kvbel_ifs
// Valid/ready channels for blob bytes and locator results.
// ----------------------------------------------------------------------------
interface kvbel_req_if;
   logic             valid;
   logic             ready;
   kvbel_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface kvbel_rsp_if;
   logic             valid;
   logic             ready;
   kvbel_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/kv_blob_entry_locator.sv =====
// ----------------------------------------------------------------------------
// kv_blob_entry_locator
// Locates one entry of a length-prefixed key/value blob, one byte per word.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries the blob one byte per word from offset zero. entry_index
//   is sampled with the first byte; last_byte marks the final byte.
//   rsp_chan gives one word per blob, after its final byte: status and the
//   key/value offsets and lengths (zero unless status is ok).
//   Throughput: one byte per cycle while no result is held and not taken;
//   the parse state is a set of small counters updated by each byte.
//   Latency: the result word is valid the cycle after the final byte is
//   taken. A new blob may start in that same cycle.
//   Stall: the result register holds its word while rsp_chan.ready is low;
//   req_chan.ready drops only while a result is held and not taken.
//   Reset: synchronous, clears the parser to expect a version byte and
//   empties the result register.
// ----------------------------------------------------------------------------
module kv_blob_entry_locator (
   input  logic        clock,
   input  logic        reset,
   kvbel_req_if.sink   req_chan,
   kvbel_rsp_if.source rsp_chan
);
   import kvbel_pkg::*;

   logic    space;
   logic    step;
   logic    emit;
   rsp_type result;

   assign req_chan.ready = space;
   assign step           = req_chan.valid && space;

   kvbel_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (req_chan.data),
      .emit   (emit),
      .result (result)
   );

   kvbel_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .load_data (result),
      .space     (space),
      .rsp_chan  (rsp_chan)
   );

   a_emit_on_last: assert property (@(posedge clock) disable iff (reset)
      emit |-> (step && req_chan.data.last_byte))
      else $error("result produced without a final byte");

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (step && req_chan.data.last_byte) |=> rsp_chan.valid)
      else $error("final byte gave no result");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.data.status != ST_OK) |->
         (rsp_chan.data.key_offset == '0 && rsp_chan.data.key_length == '0 &&
          rsp_chan.data.value_offset == '0 && rsp_chan.data.value_length == '0))
      else $error("nonzero fields on failed lookup");

   a_value_follows_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.data.status == ST_OK) |->
         (rsp_chan.data.value_offset ==
          rsp_chan.data.key_offset + POS_W'(rsp_chan.data.key_length)))
      else $error("value offset does not follow key");

endmodule

// ===== hdl/kvbel_parser.sv =====
// ----------------------------------------------------------------------------
// kvbel_parser
// Per-byte blob walker: header check, record counting, result build.
// ----------------------------------------------------------------------------
module kvbel_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  kvbel_pkg::req_type item,
   output logic               emit,
   output kvbel_pkg::rsp_type result
);
   import kvbel_pkg::*;

   typedef enum logic [7:0] {
      PH_VERSION = 8'b0000_0001,
      PH_COUNT   = 8'b0000_0010,
      PH_KEYLEN  = 8'b0000_0100,
      PH_VLO     = 8'b0000_1000,
      PH_VHI     = 8'b0001_0000,
      PH_SKIP    = 8'b0010_0000,
      PH_TARGET  = 8'b0100_0000,
      PH_DRAIN   = 8'b1000_0000
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        wanted_ff, wanted_in;
   logic [7:0]        seen_ff, seen_in;
   logic [KLEN_W-1:0] klen_ff, klen_in;
   logic [VLEN_W-1:0] vlen_ff, vlen_in;
   logic [SKIP_W-1:0] skip_ff, skip_in;
   logic              hbad_ff, hbad_in;
   logic [POS_W-1:0]  found_ff, found_in;
   status_type        drain_ff, drain_in;
   status_type        st;
   logic [SKIP_W-1:0] skip_dec;
   logic [SKIP_W-1:0] skip_sum;

   always_comb begin
      skip_dec = (skip_ff != '0) ? skip_ff - SKIP_W'(1) : skip_ff;
      skip_sum = SKIP_W'(klen_ff) + SKIP_W'({item.blob_byte, vlen_ff[7:0]});
   end

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      wanted_in = wanted_ff;
      seen_in   = seen_ff;
      klen_in   = klen_ff;
      vlen_in   = vlen_ff;
      skip_in   = skip_ff;
      hbad_in   = hbad_ff;
      found_in  = found_ff;
      drain_in  = drain_ff;
      emit      = 1'b0;
      st        = ST_TRUNC;
      result    = '0;
      if (step) begin
         if (pos_ff != POS_MAX) begin
            pos_in = pos_ff + POS_W'(1);
         end
         unique case (phase_ff)
            PH_VERSION: begin
               wanted_in = item.entry_index;
               hbad_in   = (item.blob_byte != VERSION1);
               st        = ST_BAD;
               emit      = item.last_byte;
               phase_in  = PH_COUNT;
            end
            PH_COUNT: begin
               if (hbad_ff) begin
                  st = ST_BAD;
               end else if (wanted_ff >= item.blob_byte) begin
                  st = ST_RANGE;
               end else begin
                  st = ST_TRUNC;
               end
               emit = item.last_byte;
               if (st != ST_TRUNC) begin
                  drain_in = st;
                  phase_in = PH_DRAIN;
               end else begin
                  phase_in = PH_KEYLEN;
               end
            end
            PH_KEYLEN: begin
               klen_in  = item.blob_byte;
               emit     = item.last_byte;
               phase_in = PH_VLO;
            end
            PH_VLO: begin
               vlen_in  = {8'd0, item.blob_byte};
               emit     = item.last_byte;
               phase_in = PH_VHI;
            end
            PH_VHI: begin
               vlen_in = {item.blob_byte, vlen_ff[7:0]};
               skip_in = skip_sum;
               emit    = item.last_byte;
               if (seen_ff == wanted_ff) begin
                  found_in = pos_ff + POS_W'(1);
                  st       = (skip_sum == '0) ? ST_OK : ST_TRUNC;
                  if (skip_sum == '0) begin
                     drain_in = ST_OK;
                     phase_in = PH_DRAIN;
                  end else begin
                     phase_in = PH_TARGET;
                  end
               end else begin
                  seen_in  = seen_ff + 8'd1;
                  phase_in = (skip_sum == '0) ? PH_KEYLEN : PH_SKIP;
               end
            end
            PH_SKIP: begin
               emit    = item.last_byte;
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  phase_in = PH_KEYLEN;
               end
            end
            PH_TARGET: begin
               skip_in = skip_dec;
               emit    = item.last_byte;
               st      = (skip_dec == '0) ? ST_OK : ST_TRUNC;
               if (skip_dec == '0) begin
                  drain_in = ST_OK;
                  phase_in = PH_DRAIN;
               end
            end
            PH_DRAIN: begin
               emit = item.last_byte;
               st   = drain_ff;
            end
            default: begin
               phase_in = PH_VERSION;
            end
         endcase
         if (emit) begin
            result.status = st;
            if (st == ST_OK) begin
               result.key_offset   = found_in;
               result.key_length   = klen_in;
               result.value_offset = found_in + POS_W'(klen_in);
               result.value_length = vlen_in;
            end
            phase_in  = PH_VERSION;
            pos_in    = '0;
            wanted_in = '0;
            seen_in   = '0;
            klen_in   = '0;
            vlen_in   = '0;
            skip_in   = '0;
            hbad_in   = 1'b0;
            found_in  = '0;
            drain_in  = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_VERSION;
         pos_ff    <= '0;
         wanted_ff <= '0;
         seen_ff   <= '0;
         klen_ff   <= '0;
         vlen_ff   <= '0;
         skip_ff   <= '0;
         hbad_ff   <= 1'b0;
         found_ff  <= '0;
         drain_ff  <= ST_OK;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         wanted_ff <= wanted_in;
         seen_ff   <= seen_in;
         klen_ff   <= klen_in;
         vlen_ff   <= vlen_in;
         skip_ff   <= skip_in;
         hbad_ff   <= hbad_in;
         found_ff  <= found_in;
         drain_ff  <= drain_in;
      end
   end

endmodule

// ===== hdl/kvbel_out_reg.sv =====
// ----------------------------------------------------------------------------
// kvbel_out_reg
// Result register; frees itself in the cycle the receiver takes the word.
// ----------------------------------------------------------------------------
module kvbel_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  kvbel_pkg::rsp_type load_data,
   output logic               space,
   kvbel_rsp_if.source        rsp_chan
);
   import kvbel_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign space = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.data  = data_ff;

endmodule

// ===== dv/kvbel_locate_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvbel_locate_checker
// Watches both channels of the entry locator, walks every accepted blob
// byte through its own copy of the record parser, queues the located entry
// that each final byte should produce and compares every result word with
// the oldest one, field by field.
// ----------------------------------------------------------------------------
module kvbel_locate_checker
   import kvbel_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   kvbel_req_if        req_mon,
   kvbel_rsp_if        rsp_mon,
   output int          fail_count,
   output int          pending_count,
   output int unsigned status_tally [4]
);

   typedef enum logic [2:0] {
      WANT_VERSION,
      WANT_COUNT,
      WANT_KEYLEN,
      WANT_VLEN_LO,
      WANT_VLEN_HI,
      SKIP_BODY,
      TARGET_BODY,
      DRAIN_TAIL
   } walk_state_type;

   walk_state_type    walk;
   logic [POS_W-1:0]  byte_pos;
   logic [POS_W-1:0]  key_pos;
   logic [7:0]        want_idx;
   logic [7:0]        entry_cnt;
   logic [7:0]        entries_done;
   logic [KLEN_W-1:0] key_len;
   logic [VLEN_W-1:0] val_len;
   logic [SKIP_W-1:0] body_left;
   logic              hdr_bad;
   status_type        tail_status;
   rsp_type           located_entries [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
   end

   function automatic void clear_walk();
      walk         = WANT_VERSION;
      byte_pos     = '0;
      key_pos      = '0;
      want_idx     = '0;
      entry_cnt    = '0;
      entries_done = '0;
      key_len      = '0;
      val_len      = '0;
      body_left    = '0;
      hdr_bad      = 1'b0;
      tail_status  = ST_OK;
   endfunction

   function automatic void close_blob(input status_type s);
      rsp_type r;
      r = '0;
      r.status = s;
      if (s == ST_OK) begin
         r.key_offset   = key_pos;
         r.key_length   = key_len;
         r.value_offset = key_pos + key_len;
         r.value_length = val_len;
      end
      located_entries.push_back(r);
      clear_walk();
   endfunction

   function automatic void walk_blob_byte(input req_type w);
      logic [POS_W-1:0] here;
      status_type       st;
      here = byte_pos;
      st   = ST_TRUNC;
      if (byte_pos != POS_MAX) byte_pos = byte_pos + 1'b1;
      case (walk)
         WANT_VERSION: begin
            want_idx = w.entry_index;
            hdr_bad  = (w.blob_byte != VERSION1);
            if (w.last_byte) close_blob(ST_BAD);
            else walk = WANT_COUNT;
         end
         WANT_COUNT: begin
            entry_cnt = w.blob_byte;
            if (hdr_bad) st = ST_BAD;
            else if (want_idx >= entry_cnt) st = ST_RANGE;
            if (w.last_byte) begin
               close_blob(st);
            end else if (st != ST_TRUNC) begin
               tail_status = st;
               walk        = DRAIN_TAIL;
            end else begin
               walk = WANT_KEYLEN;
            end
         end
         WANT_KEYLEN: begin
            key_len = w.blob_byte;
            if (w.last_byte) close_blob(ST_TRUNC);
            else walk = WANT_VLEN_LO;
         end
         WANT_VLEN_LO: begin
            val_len[7:0] = w.blob_byte;
            if (w.last_byte) close_blob(ST_TRUNC);
            else walk = WANT_VLEN_HI;
         end
         WANT_VLEN_HI: begin
            val_len[15:8] = w.blob_byte;
            body_left     = {1'b0, val_len} + key_len;
            if (entries_done == want_idx) begin
               key_pos = here + 1'b1;
               if (w.last_byte) begin
                  close_blob((body_left == 0) ? ST_OK : ST_TRUNC);
               end else if (body_left == 0) begin
                  tail_status = ST_OK;
                  walk        = DRAIN_TAIL;
               end else begin
                  walk = TARGET_BODY;
               end
            end else if (w.last_byte) begin
               close_blob(ST_TRUNC);
            end else begin
               entries_done = entries_done + 1'b1;
               walk = (body_left == 0) ? WANT_KEYLEN : SKIP_BODY;
            end
         end
         SKIP_BODY: begin
            if (w.last_byte) begin
               close_blob(ST_TRUNC);
            end else begin
               if (body_left != 0) body_left = body_left - 1'b1;
               if (body_left == 0) walk = WANT_KEYLEN;
            end
         end
         TARGET_BODY: begin
            if (body_left != 0) body_left = body_left - 1'b1;
            if (w.last_byte) begin
               close_blob((body_left == 0) ? ST_OK : ST_TRUNC);
            end else if (body_left == 0) begin
               tail_status = ST_OK;
               walk        = DRAIN_TAIL;
            end
         end
         default: begin
            if (w.last_byte) close_blob(tail_status);
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) begin
         fail_count++;
         $display("%0t kvbel_locate_checker: %s mismatch, expected %0d actual %0d",
                  $time, name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         clear_walk();
         located_entries.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.data;
            if (located_entries.size() == 0) begin
               fail_count++;
               $display("%0t kvbel_locate_checker: unexpected word, expected none actual %h",
                        $time, got);
            end else begin
               want = located_entries.pop_front();
               status_tally[want.status]++;
               check_field("status",       want.status,       got.status);
               check_field("key_offset",   want.key_offset,   got.key_offset);
               check_field("key_length",   want.key_length,   got.key_length);
               check_field("value_offset", want.value_offset, got.value_offset);
               check_field("value_length", want.value_length, got.value_length);
            end
         end
         if (req_mon.valid && req_mon.ready) walk_blob_byte(req_mon.data);
      end
      pending_count = located_entries.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives blobs into the key/value blob entry locator: a few hand-built
// blobs for the header, range, truncation and empty-record cases, then
// random well-formed, cut-short, bad-version and noise blobs under four
// idling mixes, a long result hold-off, a 255-entry walk and a cut-short
// record with maximal lengths. The checker predicts and compares; this
// module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import kvbel_pkg::*;

   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_BYTES  = 345;
   localparam int SEND_PCT [4] = '{0, 67, 0, 30};
   localparam int RECV_PCT [4] = '{0, 0, 67, 30};

   logic clock;
   logic reset;

   kvbel_req_if req_if ();
   kvbel_rsp_if rsp_if ();

   int          fail_count;
   int          pending_count;
   int unsigned status_tally [4];

   int          send_idle_pct;
   int          recv_stall_pct;
   logic        hold_request;
   logic        hold_done;
   int          bytes_sent;
   int          blobs_sent;
   int          stall_cycles;
   logic [7:0]  blob_q [$];
   logic [7:0]  blob_want;

   kv_blob_entry_locator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   kvbel_locate_checker chk (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_if),
      .rsp_mon       (rsp_if),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .status_tally  (status_tally)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      hold_done    = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_if.ready <= 1'b0;
         end else if (hold_request && !hold_done) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("%0t tb_top: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb_top: FAIL");
      $finish;
   end

   task automatic send_word(input req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= w;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_blob();
      req_type w;
      foreach (blob_q[i]) begin
         w.blob_byte   = blob_q[i];
         w.entry_index = (i == 0) ? blob_want : 8'($urandom_range(255));
         w.last_byte   = (i == blob_q.size() - 1);
         send_word(w);
      end
      blobs_sent++;
   endtask

   task automatic pause_until_drained();
      req_if.valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   task automatic make_record_blob();
      int n_ent;
      int want;
      int n_rec;
      int klen;
      int vlen;
      int cut;
      blob_q.delete();
      if ($urandom_range(9) == 0) n_ent = $urandom_range(255);
      else n_ent = $urandom_range(7);
      if (n_ent > 0 && $urandom_range(9) < 8)
         want = $urandom_range((n_ent > 8) ? 7 : n_ent - 1);
      else
         want = $urandom_range(255, n_ent);
      n_rec     = (want < n_ent) ? want + 1 : $urandom_range(2);
      blob_want = want[7:0];
      blob_q.push_back(VERSION1);
      blob_q.push_back(n_ent[7:0]);
      repeat (n_rec) begin
         klen = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(4);
         case ($urandom_range(19))
            0:          vlen = $urandom_range(300, 256);
            1, 2, 3, 4: vlen = $urandom_range(40);
            default:    vlen = $urandom_range(6);
         endcase
         blob_q.push_back(klen[7:0]);
         blob_q.push_back(vlen[7:0]);
         blob_q.push_back(vlen[15:8]);
         repeat (klen + vlen) blob_q.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(1)) repeat ($urandom_range(3)) blob_q.push_back(8'($urandom_range(255)));
      if ($urandom_range(4) == 0) begin
         cut    = $urandom_range(blob_q.size() - 1, 1);
         blob_q = blob_q[0:cut-1];
      end
   endtask

   task automatic random_blob();
      int pick;
      logic [7:0] first;
      pick = $urandom_range(99);
      if (pick < 70) begin
         make_record_blob();
      end else begin
         blob_q.delete();
         blob_want = 8'($urandom_range(255));
         first     = 8'($urandom_range(255));
         if (pick < 85 && first == VERSION1) first = 8'h00;
         blob_q.push_back(first);
         repeat ($urandom_range(9)) blob_q.push_back(8'($urandom_range(255)));
      end
      send_blob();
   endtask

   initial begin
      int phase_start;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.data    = '0;
      hold_request   = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      bytes_sent     = 0;
      blobs_sent     = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = SEND_PCT[ph];
         recv_stall_pct = RECV_PCT[ph];
         phase_start    = bytes_sent;
         if (ph == 0) begin
            // one-byte blob, bad version, count zero, empty record,
            // cut inside a record header, small ok record
            blob_want = 8'd0;   blob_q = '{8'h01};                    send_blob();
            blob_want = 8'd0;   blob_q = '{8'hFF, 8'h02};             send_blob();
            blob_want = 8'd255; blob_q = '{8'h01, 8'h00};             send_blob();
            blob_want = 8'd0;   blob_q = '{8'h01, 8'h01, 8'h00, 8'h00, 8'h00};
            send_blob();
            blob_want = 8'd1;   blob_q = '{8'h01, 8'h02, 8'h00, 8'h00};
            send_blob();
            blob_want = 8'd0;
            blob_q = '{8'h01, 8'h01, 8'h02, 8'h01, 8'h00, 8'hAA, 8'h55, 8'hC3};
            send_blob();

            hold_request = 1'b1;
            while (!hold_done) random_blob();

            // deepest walk: last of 255 empty records
            blob_want = 8'd254;
            blob_q    = '{8'h01, 8'hFF};
            repeat (255) begin
               blob_q.push_back(8'h00);
               blob_q.push_back(8'h00);
               blob_q.push_back(8'h00);
            end
            send_blob();
            blob_want = 8'd255; blob_q = '{8'h01, 8'hFF, 8'h00};      send_blob();

            // longest key with the longest value, cut short in the body
            blob_want = 8'd0;
            blob_q    = '{8'h01, 8'h01, 8'hFF, 8'hFF, 8'hFF};
            repeat (40) blob_q.push_back(8'($urandom_range(255)));
            send_blob();
            pause_until_drained();
         end
         while (bytes_sent - phase_start < PHASE_BYTES) random_blob();
         pause_until_drained();
      end

      repeat (8) @(posedge clock);
      $display("tb_top: %0d bytes in %0d blobs over four idling mixes with a long hold-off",
               bytes_sent, blobs_sent);
      $display("tb_top: results ok %0d, bad header %0d, out of range %0d, truncated %0d",
               status_tally[ST_OK], status_tally[ST_BAD], status_tally[ST_RANGE],
               status_tally[ST_TRUNC]);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
